// ----- rtl/core/bm3_pkg.sv -----
// bm3_pkg: shared types and constants for the 3x3 binary morphology block
// used by bm3_window, bm3_out_queue and binary_morphology_3x3
// no dependencies
package bm3_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_DIM_W  = 11;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int N_RES      = 4;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [THR_W-1:0]     THR_RST    = 8'd127;
    localparam logic [PIX_W-1:0]     PIX_ON     = 8'd255;
    localparam logic [PIX_W-1:0]     PIX_OFF    = 8'd0;

    // result slots of one item, in raster order
    localparam int RES_PROW_PCOL = 0;
    localparam int RES_PROW_CCOL = 1;
    localparam int RES_CROW_PCOL = 2;
    localparam int RES_CROW_CCOL = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic mode;
        logic hit;
        logic last_col;
        logic last_row;
    } item_flags_t;

    typedef struct packed {
        logic prev;
        logic prev2;
    } line_entry_t;

    typedef struct packed {
        logic [N_RES-1:0] mask;
        logic [N_RES-1:0] pix;
    } grp_flags_t;

endpackage

// ----- rtl/core/bm3_window.sv -----
// bm3_window: line buffer memory with read-modify-write, 3x3 window and result forming
// depends on bm3_pkg
module bm3_window import bm3_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int XW        = 10,
    parameter int YW        = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic [XW-1:0] in_x,
    input  logic [YW-1:0] in_y,
    input  item_flags_t   in_flags,
    output logic          s1_valid,
    output logic          push,
    output grp_flags_t    push_flags,
    output logic [XW-1:0] push_x,
    output logic [YW-1:0] push_y
);

    line_entry_t   line_mem [MAX_WIDTH];
    line_entry_t   rd_data_reg;
    line_entry_t   fwd_data_reg;
    logic          fwd_reg;
    logic          s1_valid_reg;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    item_flags_t   s1_flags_reg;
    logic [8:0]    win_reg;
    logic [8:0]    win_next;

    line_entry_t   rd_ent;
    line_entry_t   wr_ent;
    logic          top_bit;
    logic          mid_bit;
    logic [2:0]    col;
    logic [8:0]    win_x;
    grp_flags_t    grp;

    function automatic logic any_mid(input logic [8:0] v);
        any_mid = |{v[8:5], v[3:0]};
    endfunction

    function automatic logic any_bot(input logic [8:0] v);
        any_bot = v[1] | v[2] | v[4] | v[5] | v[7] | v[8];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            s1_valid_reg <= in_valid;
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_x_reg     <= in_x;
            s1_y_reg     <= in_y;
            s1_flags_reg <= in_flags;
            // same entry written back this edge: take the new value
            fwd_reg      <= s1_valid_reg && (s1_x_reg == in_x);
            fwd_data_reg <= wr_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            rd_data_reg <= line_mem[in_x];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            line_mem[s1_x_reg] <= wr_ent;
        end
    end

    always_comb begin
        rd_ent      = fwd_reg ? fwd_data_reg : rd_data_reg;
        top_bit     = (s1_y_reg == '0) ? s1_flags_reg.hit : rd_ent.prev2;
        mid_bit     = (s1_y_reg == '0) ? s1_flags_reg.hit : rd_ent.prev;
        wr_ent.prev  = s1_flags_reg.hit;
        wr_ent.prev2 = mid_bit;
        col         = {s1_flags_reg.hit, mid_bit, top_bit};
        win_next    = (s1_x_reg == '0) ? {col, col, col} : {col, win_reg[8:3]};
        win_x       = {col, win_next[8:3]};

        grp.pix[RES_PROW_PCOL] = any_mid(win_next) ^ s1_flags_reg.mode;
        grp.pix[RES_PROW_CCOL] = any_mid(win_x)    ^ s1_flags_reg.mode;
        grp.pix[RES_CROW_PCOL] = any_bot(win_next) ^ s1_flags_reg.mode;
        grp.pix[RES_CROW_CCOL] = any_bot(win_x)    ^ s1_flags_reg.mode;

        grp.mask[RES_PROW_PCOL] = (s1_y_reg != '0) && (s1_x_reg != '0);
        grp.mask[RES_PROW_CCOL] = (s1_y_reg != '0) && s1_flags_reg.last_col;
        grp.mask[RES_CROW_PCOL] = s1_flags_reg.last_row && (s1_x_reg != '0);
        grp.mask[RES_CROW_CCOL] = s1_flags_reg.last_row && s1_flags_reg.last_col;
    end

    assign s1_valid   = s1_valid_reg;
    assign push       = s1_valid_reg && (grp.mask != '0);
    assign push_flags = grp;
    assign push_x     = s1_x_reg;
    assign push_y     = s1_y_reg;

endmodule

// ----- rtl/core/bm3_out_queue.sv -----
// bm3_out_queue: queue of per-item result groups and the serializer onto the output stream
// depends on bm3_pkg
module bm3_out_queue import bm3_pkg::*; #(
    parameter int XW = 10,
    parameter int YW = 10,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  grp_flags_t    push_flags,
    input  logic [XW-1:0] push_x,
    input  logic [YW-1:0] push_y,
    output logic [QAW:0]  count,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [DW-1:0] m_tdata,   // out_pixel, out_x, out_y, zero pad
    output logic          m_tlast    // frame_last
);

    grp_flags_t    flags_q [QDEPTH];
    logic [XW-1:0] x_q     [QDEPTH];
    logic [YW-1:0] y_q     [QDEPTH];

    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     cnt_reg;
    logic [QAW:0]     cnt_next;
    logic [N_RES-1:0] done_reg;
    logic [N_RES-1:0] done_next;

    grp_flags_t       head;
    logic [N_RES-1:0] rem;
    logic [N_RES-1:0] sel;
    logic             grp_done;
    logic             pop_res;
    logic             pop_grp;
    logic [XW-1:0]    out_x;
    logic [YW-1:0]    out_y;
    logic [PIX_W-1:0] out_pixel;

    always_ff @(posedge aclk) begin
        if (push) begin
            flags_q[wr_ptr_reg] <= push_flags;
            x_q[wr_ptr_reg]     <= push_x;
            y_q[wr_ptr_reg]     <= push_y;
        end
    end

    always_comb begin
        head      = flags_q[rd_ptr_reg];
        rem       = head.mask & ~done_reg;
        sel       = rem & (~rem + N_RES'(1));
        grp_done  = (rem & ~sel) == '0;
        m_tvalid  = cnt_reg != '0;
        pop_res   = m_tvalid && m_tready;
        pop_grp   = pop_res && grp_done;
        out_x     = x_q[rd_ptr_reg] - XW'(sel[RES_PROW_PCOL] | sel[RES_CROW_PCOL]);
        out_y     = y_q[rd_ptr_reg] - YW'(sel[RES_PROW_PCOL] | sel[RES_PROW_CCOL]);
        out_pixel = ((sel & head.pix) != '0) ? PIX_ON : PIX_OFF;
        m_tdata   = DW'({out_y, out_x, out_pixel});
        m_tlast   = sel[RES_CROW_CCOL];

        cnt_next = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop_grp);
        if (pop_grp) begin
            done_next = '0;
        end else if (pop_res) begin
            done_next = done_reg | sel;
        end else begin
            done_next = done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            done_reg   <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop_grp) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
        end
    end

    assign count = cnt_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QDEPTH)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg < QDEPTH) || pop_grp)
        else $error("result queue overflow");

    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(sel))
        else $error("queued group has no result left");

endmodule

// ----- rtl/core/binary_morphology_3x3.sv -----
// binary_morphology_3x3: top level, configuration registers, raster counters, hit bit
// depends on bm3_pkg, bm3_window, bm3_out_queue
// an item's results are registered in the window stage, then in the result queue
// throughput: 1 item per cycle; the queue drains 1 result per cycle with m_tready high,
//   so row ends (2 results) and the last row (up to 4 per item) hold s_tready low as needed
// reset: config back to dilate/640/480/127, counters, window and queue cleared;
//   line buffer memory is not cleared, row 0 primes it
module binary_morphology_3x3 import bm3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((PIX_W + $clog2(MAX_WIDTH)
                    + ((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1) + 7) / 8) * 8 - 1:0]
                                  m_tdata,   // out_pixel, out_x, out_y, zero pad
    output logic                  m_tlast,   // frame_last
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW = ((PIX_W + XW + YW + 7) / 8) * 8;
    localparam int GXW = (XW + 1 > CFG_DIM_W) ? XW + 1 : CFG_DIM_W;
    localparam int GYW = (YW + 1 > CFG_DIM_W) ? YW + 1 : CFG_DIM_W;

    logic                 mode_reg;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [XW-1:0]        col_reg;
    logic [XW-1:0]        col_next;
    logic [YW-1:0]        row_reg;
    logic [YW-1:0]        row_next;

    logic [GXW-1:0] width_lim;
    logic [GYW-1:0] height_lim;
    logic           accept;
    item_flags_t    flags;
    logic           s1_valid;
    logic           push;
    grp_flags_t     push_flags;
    logic [XW-1:0]  push_x;
    logic [YW-1:0]  push_y;
    logic [QAW:0]   q_count;
    logic [QAW+1:0] q_need;

    always_comb begin
        if (width_reg == '0) begin
            width_lim = GXW'(1);
        end else if (GXW'(width_reg) > GXW'(MAX_WIDTH)) begin
            width_lim = GXW'(MAX_WIDTH);
        end else begin
            width_lim = GXW'(width_reg);
        end
        if (height_reg == '0) begin
            height_lim = GYW'(1);
        end else if (GYW'(height_reg) > GYW'(MAX_HEIGHT)) begin
            height_lim = GYW'(MAX_HEIGHT);
        end else begin
            height_lim = GYW'(height_reg);
        end

        flags.mode     = mode_reg;
        flags.hit      = mode_reg ? (s_tdata < thr_reg) : (s_tdata > thr_reg);
        flags.last_col = (GXW'(col_reg) + GXW'(1)) >= width_lim;
        flags.last_row = (GYW'(row_reg) + GYW'(1)) >= height_lim;

        if (flags.last_col) begin
            col_next = '0;
            row_next = flags.last_row ? '0 : row_reg + YW'(1);
        end else begin
            col_next = col_reg + XW'(1);
            row_next = row_reg;
        end

        q_need   = {1'b0, q_count} + (QAW+2)'(s1_valid);
        s_tready = q_need < (QAW+2)'(QDEPTH);
        accept   = s_tvalid && s_tready;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            thr_reg    <= THR_RST;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MODE:      mode_reg   <= cfg_data[0];
                    REG_WIDTH:     width_reg  <= cfg_data;
                    REG_HEIGHT:    height_reg <= cfg_data;
                    REG_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    bm3_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .XW        (XW),
        .YW        (YW)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (accept),
        .in_x       (col_reg),
        .in_y       (row_reg),
        .in_flags   (flags),
        .s1_valid   (s1_valid),
        .push       (push),
        .push_flags (push_flags),
        .push_x     (push_x),
        .push_y     (push_y)
    );

    bm3_out_queue #(
        .XW (XW),
        .YW (YW),
        .DW (DW)
    ) u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_flags (push_flags),
        .push_x     (push_x),
        .push_y     (push_y),
        .count      (q_count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
